FILE: design/pblp_pkg.sv
// ----------------------------------------------------------------------------
// pblp_pkg
// Shared types and constants for the power/battery LED pattern block.
// ----------------------------------------------------------------------------
package pblp_pkg;

  localparam int CAPACITY_BITS_DEF = 16;
  localparam int PERMILLE_SCALE    = 1000;
  localparam int PERMILLE_BITS     = 10;
  localparam int SCALE_BITS        = 10;   // bits of PERMILLE_SCALE
  localparam int CFG_INDEX_BITS    = 3;

  localparam logic [PERMILLE_BITS-1:0] CRITICAL_PERMILLE_RST = 10'd71;
  localparam logic [PERMILLE_BITS-1:0] LOW_PERMILLE_RST      = 10'd137;
  localparam logic [PERMILLE_BITS-1:0] FULL_PERMILLE_RST     = 10'd937;

  // register indexes on the config port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CRITICAL_PERMILLE   = 3'd0,
    REG_LOW_PERMILLE        = 3'd1,
    REG_FULL_PERMILLE       = 3'd2,
    REG_POWER_AUTO_ENABLE   = 3'd3,
    REG_BATTERY_AUTO_ENABLE = 3'd4
  } reg_index_t;

  // chipset states
  localparam logic [1:0] CHIP_OFF     = 2'd0;
  localparam logic [1:0] CHIP_SUSPEND = 2'd1;
  localparam logic [1:0] CHIP_ON      = 2'd2;

  // charge states
  localparam logic [2:0] CHG_CHARGE    = 3'd0;
  localparam logic [2:0] CHG_NEAR_FULL = 3'd1;
  localparam logic [2:0] CHG_DISCHARGE = 3'd2;
  localparam logic [2:0] CHG_ERROR     = 3'd3;
  localparam logic [2:0] CHG_IDLE      = 3'd4;

  // bit 0 drives blue, bit 1 drives amber
  typedef enum logic [1:0] {
    COLOR_OFF   = 2'd0,
    COLOR_BLUE  = 2'd1,
    COLOR_AMBER = 2'd2,
    COLOR_BOTH  = 2'd3
  } color_t;

  typedef struct packed {
    logic [PERMILLE_BITS-1:0] critical_permille;
    logic [PERMILLE_BITS-1:0] low_permille;
    logic [PERMILLE_BITS-1:0] full_permille;
    logic                     power_auto_enable;
    logic                     battery_auto_enable;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture request fields
    logic mul;       // scale remaining capacity, clear divider
    logic div_step;  // one quotient bit
    logic update;    // advance counters and colors
  } cmd_t;

endpackage

FILE: design/pblp_ctrl.sv
// ----------------------------------------------------------------------------
// pblp_ctrl
// Sequencer: capture, scale, bit-serial divide, pattern update.
// ----------------------------------------------------------------------------
module pblp_ctrl #(
  parameter int CAPACITY_BITS = pblp_pkg::CAPACITY_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output pblp_pkg::cmd_t  cmd
);

  localparam int STEPS = CAPACITY_BITS + pblp_pkg::SCALE_BITS;
  localparam int CNT_W = $clog2(STEPS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire;
  logic             out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // colors feed the pins directly, so wait until the last result left
        if (out_free) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_fire_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_MUL)
    else $error("accepted request did not start scaling");

  a_update_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (!out_valid_r || out_tready))
    else $error("colors changed under a pending result");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPD))
    else $error("result raised outside update");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r <= CNT_W'(STEPS - 1))
    else $error("divide step count out of range");

endmodule

FILE: design/pblp_datapath.sv
// ----------------------------------------------------------------------------
// pblp_datapath
// Permille scaler and divider, tick counters and LED color state.
// ----------------------------------------------------------------------------
module pblp_datapath #(
  parameter int CAPACITY_BITS = pblp_pkg::CAPACITY_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pblp_pkg::cmd_t           cmd,
  input  pblp_pkg::cfg_t           cfg,
  input  logic [1:0]               chip_state,
  input  logic [2:0]               charge_mode,
  input  logic                     force_idle,
  input  logic [CAPACITY_BITS-1:0] rem_capacity,
  input  logic [CAPACITY_BITS-1:0] full_capacity,
  output pblp_pkg::color_t         power_color,
  output pblp_pkg::color_t         battery_color
);

  localparam int NW = CAPACITY_BITS + pblp_pkg::SCALE_BITS;

  // captured request
  logic [1:0]               chip_r;
  logic [2:0]               chg_r;
  logic                     idle_r;
  logic [CAPACITY_BITS-1:0] rem_r;
  logic [CAPACITY_BITS-1:0] full_r;

  // divider: num_r shifts dividend out, quotient in
  logic [NW-1:0]            num_r;
  logic [CAPACITY_BITS-1:0] part_r;
  logic [CAPACITY_BITS:0]   trial;
  logic [CAPACITY_BITS:0]   diff;
  logic                     ge;
  logic [NW-1:0]            pm;

  // pattern state
  logic [3:0]               pcnt_r, pcnt_nxt;
  logic [3:0]               bcnt_r, bcnt_nxt;
  logic                     susp_r, susp_nxt;
  pblp_pkg::color_t         pcol_r, pcol_nxt;
  pblp_pkg::color_t         bcol_r, bcol_nxt;
  logic [3:0]               pinc, binc;
  logic                     not_off, fast_on, slow_on;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chip_r <= chip_state;
      chg_r  <= charge_mode;
      idle_r <= force_idle;
      rem_r  <= rem_capacity;
      full_r <= full_capacity;
    end
  end

  assign trial = {part_r, num_r[NW-1]};
  assign diff  = trial - {1'b0, full_r};
  assign ge    = (trial >= {1'b0, full_r});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num_r  <= {{pblp_pkg::SCALE_BITS{1'b0}}, rem_r} * NW'(pblp_pkg::PERMILLE_SCALE);
      part_r <= '0;
    end else if (cmd.div_step) begin
      num_r  <= {num_r[NW-2:0], ge};
      part_r <= ge ? diff[CAPACITY_BITS-1:0] : trial[CAPACITY_BITS-1:0];
    end
  end

  // unknown full capacity reads as zero charge
  assign pm = (full_r == '0) ? '0 : num_r;

  always_comb begin
    pcnt_nxt = pcnt_r;
    susp_nxt = susp_r;
    pcol_nxt = pcol_r;
    pinc     = pcnt_r + 4'd1;
    if (cmd.update && cfg.power_auto_enable) begin
      if (chip_r == pblp_pkg::CHIP_SUSPEND) begin
        pcnt_nxt = susp_r ? pinc : 4'd0;
        pcol_nxt = (pcnt_nxt[3:2] == 2'd0) ? pblp_pkg::COLOR_AMBER : pblp_pkg::COLOR_OFF;
        susp_nxt = 1'b1;
      end else begin
        pcnt_nxt = pinc;
        susp_nxt = 1'b0;
        if (chip_r == pblp_pkg::CHIP_OFF) begin
          pcol_nxt = pblp_pkg::COLOR_OFF;
        end else if (chip_r == pblp_pkg::CHIP_ON) begin
          pcol_nxt = pblp_pkg::COLOR_BLUE;
        end
      end
    end
  end

  always_comb begin
    bcnt_nxt = bcnt_r;
    bcol_nxt = bcol_r;
    binc     = bcnt_r + 4'd1;
    not_off  = (chip_r != pblp_pkg::CHIP_OFF);
    fast_on  = !binc[2];
    slow_on  = (binc[3:2] == 2'd0);
    if (cmd.update && cfg.battery_auto_enable) begin
      bcnt_nxt = binc;
      unique case (chg_r)
        pblp_pkg::CHG_CHARGE: begin
          bcol_nxt = (pm < NW'(cfg.full_permille)) ? pblp_pkg::COLOR_AMBER
                                                   : pblp_pkg::COLOR_BLUE;
        end
        pblp_pkg::CHG_NEAR_FULL: bcol_nxt = pblp_pkg::COLOR_BLUE;
        pblp_pkg::CHG_DISCHARGE: begin
          if (not_off && pm <= NW'(cfg.critical_permille)) begin
            bcol_nxt = fast_on ? pblp_pkg::COLOR_AMBER : pblp_pkg::COLOR_OFF;
          end else if (not_off && pm <= NW'(cfg.low_permille)) begin
            bcol_nxt = slow_on ? pblp_pkg::COLOR_AMBER : pblp_pkg::COLOR_OFF;
          end else begin
            bcol_nxt = pblp_pkg::COLOR_OFF;
          end
        end
        pblp_pkg::CHG_ERROR: begin
          bcol_nxt = fast_on ? pblp_pkg::COLOR_AMBER : pblp_pkg::COLOR_OFF;
        end
        pblp_pkg::CHG_IDLE: begin
          if (idle_r) begin
            bcol_nxt = binc[3] ? pblp_pkg::COLOR_AMBER : pblp_pkg::COLOR_BLUE;
          end else begin
            bcol_nxt = pblp_pkg::COLOR_BLUE;
          end
        end
        default: bcol_nxt = bcol_r;  // other charge states hold the color
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= '0;
      bcnt_r <= '0;
      susp_r <= 1'b0;
      pcol_r <= pblp_pkg::COLOR_OFF;
      bcol_r <= pblp_pkg::COLOR_OFF;
    end else begin
      pcnt_r <= pcnt_nxt;
      bcnt_r <= bcnt_nxt;
      susp_r <= susp_nxt;
      pcol_r <= pcol_nxt;
      bcol_r <= bcol_nxt;
    end
  end

  assign power_color   = pcol_r;
  assign battery_color = bcol_r;

endmodule

FILE: design/power_battery_led_pattern.sv
// ----------------------------------------------------------------------------
// power_battery_led_pattern
// Power and battery LED pattern generator, one request per 250 ms tick.
// ----------------------------------------------------------------------------
// Each request is one tick carrying chipset state, charge state, a force-idle
// flag and remaining/full battery capacity; each request yields one result
// holding the four active-low LED pin levels. The accepting edge captures
// the fields, then the scale state multiplies the remaining capacity by
// 1000, the divide state runs the restoring divider (CAPACITY_BITS + 10
// bits) at one quotient bit per cycle and the update state loads the
// colors. in_tready comes back as the result goes up, so a new request is
// taken only once the previous one has been through its update. One
// request is in flight at a time; a new request is accepted while the
// previous result still waits on out_tready, but its update stalls until
// that result is taken. The output pins reflect held LED colors, so they
// stay stable until the next update. A full capacity of zero reads as
// 0 permille. Configuration writes are always accepted and should only be
// issued while idle.
// ----------------------------------------------------------------------------
module power_battery_led_pattern #(
  parameter int CAPACITY_BITS = pblp_pkg::CAPACITY_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,

  // request channel
  input  logic in_tvalid,
  output logic in_tready,
  // [1:0] chip_state, [4:2] charge_mode, [5] force_idle,
  // [6 +: CAPACITY_BITS] rem_capacity,
  // [6+CAPACITY_BITS +: CAPACITY_BITS] full_capacity, rest zero pad
  input  logic [((6 + 2*CAPACITY_BITS + 7) / 8) * 8 - 1:0] in_tdata,

  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  // [0] power_blue_n, [1] power_amber_n, [2] battery_blue_n,
  // [3] battery_amber_n, [7:4] zero
  output logic [7:0] out_tdata,

  // configuration write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [pblp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [pblp_pkg::PERMILLE_BITS-1:0]      cfg_data
);

  localparam int CB = CAPACITY_BITS;

  pblp_pkg::cfg_t   cfg_r;
  pblp_pkg::cmd_t   cmd;
  pblp_pkg::color_t power_color;
  pblp_pkg::color_t battery_color;

  // register file; writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.critical_permille   <= pblp_pkg::CRITICAL_PERMILLE_RST;
      cfg_r.low_permille        <= pblp_pkg::LOW_PERMILLE_RST;
      cfg_r.full_permille       <= pblp_pkg::FULL_PERMILLE_RST;
      cfg_r.power_auto_enable   <= 1'b1;
      cfg_r.battery_auto_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pblp_pkg::REG_CRITICAL_PERMILLE:   cfg_r.critical_permille   <= cfg_data;
        pblp_pkg::REG_LOW_PERMILLE:        cfg_r.low_permille        <= cfg_data;
        pblp_pkg::REG_FULL_PERMILLE:       cfg_r.full_permille       <= cfg_data;
        pblp_pkg::REG_POWER_AUTO_ENABLE:   cfg_r.power_auto_enable   <= cfg_data[0];
        pblp_pkg::REG_BATTERY_AUTO_ENABLE: cfg_r.battery_auto_enable <= cfg_data[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  pblp_ctrl #(
    .CAPACITY_BITS (CAPACITY_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  pblp_datapath #(
    .CAPACITY_BITS (CAPACITY_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg_r),
    .chip_state         (in_tdata[1:0]),
    .charge_mode        (in_tdata[4:2]),
    .force_idle         (in_tdata[5]),
    .rem_capacity       (in_tdata[6 +: CB]),
    .full_capacity      (in_tdata[6 + CB +: CB]),
    .power_color        (power_color),
    .battery_color      (battery_color)
  );

  // color bit 0 lights blue, bit 1 lights amber; pins are active low
  assign out_tdata = {4'b0000,
                      ~battery_color[1], ~battery_color[0],
                      ~power_color[1],   ~power_color[0]};

endmodule

FILE: tb/pblp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pblp_checker
// Watches the request, result and config channels of the LED pattern block,
// keeps its own copy of the LED state and compares every result pin by pin.
// ----------------------------------------------------------------------------
module pblp_checker #(
  parameter int CAP  = pblp_pkg::CAPACITY_BITS_DEF,
  parameter int IN_W = ((6 + 2*CAP + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [IN_W-1:0]                     in_tdata,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [7:0]                          out_tdata,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [pblp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pblp_pkg::PERMILLE_BITS-1:0]  cfg_data,
  output int                                  n_pending,
  output int                                  n_errors,
  output int                                  n_checked
);

  // register copy
  logic [pblp_pkg::PERMILLE_BITS-1:0] crit_pm, low_pm, full_pm;
  logic                               pwr_auto, bat_auto;

  // LED state copy
  logic [3:0]       pwr_cnt, bat_cnt;
  logic             was_susp;
  pblp_pkg::color_t pwr_color, bat_color;

  // expected pins, [0] power_blue_n .. [3] battery_amber_n
  logic [3:0] pins_due_q[$];

  string pin_name[4] = '{"power_blue_n", "power_amber_n",
                         "battery_blue_n", "battery_amber_n"};

  task automatic report_miss(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic apply_cfg(input logic [pblp_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [pblp_pkg::PERMILLE_BITS-1:0] val);
    case (idx)
      pblp_pkg::REG_CRITICAL_PERMILLE:   crit_pm  = val;
      pblp_pkg::REG_LOW_PERMILLE:        low_pm   = val;
      pblp_pkg::REG_FULL_PERMILLE:       full_pm  = val;
      pblp_pkg::REG_POWER_AUTO_ENABLE:   pwr_auto = val[0];
      pblp_pkg::REG_BATTERY_AUTO_ENABLE: bat_auto = val[0];
      default: ;
    endcase
  endtask

  // advance the LED state by one tick and return the pin levels
  task automatic led_predict(input logic [1:0] chip, input logic [2:0] chg,
                             input logic idle, input logic [CAP-1:0] rem,
                             input logic [CAP-1:0] full, output logic [3:0] pins);
    logic [63:0] pm;
    logic        fast_on, slow_on, not_off;
    if (pwr_auto) begin
      pwr_cnt = pwr_cnt + 4'd1;
      if (chip == pblp_pkg::CHIP_SUSPEND) begin
        if (!was_susp) pwr_cnt = 4'd0;   // restart blink on suspend entry
        if (pwr_cnt < 4'd4) pwr_color = pblp_pkg::COLOR_AMBER;
        else pwr_color = pblp_pkg::COLOR_OFF;
        was_susp = 1'b1;
      end else begin
        was_susp = 1'b0;
        if (chip == pblp_pkg::CHIP_OFF) pwr_color = pblp_pkg::COLOR_OFF;
        else if (chip == pblp_pkg::CHIP_ON) pwr_color = pblp_pkg::COLOR_BLUE;
      end
    end
    if (bat_auto) begin
      bat_cnt = bat_cnt + 4'd1;
      pm      = (full == '0) ? 64'd0 : (64'(rem) * 64'd1000) / 64'(full);
      fast_on = (bat_cnt[2:0] < 3'd4);
      slow_on = (bat_cnt < 4'd4);
      not_off = (chip != pblp_pkg::CHIP_OFF);
      case (chg)
        pblp_pkg::CHG_CHARGE: begin
          if (pm < 64'(full_pm)) bat_color = pblp_pkg::COLOR_AMBER;
          else bat_color = pblp_pkg::COLOR_BLUE;
        end
        pblp_pkg::CHG_NEAR_FULL: bat_color = pblp_pkg::COLOR_BLUE;
        pblp_pkg::CHG_DISCHARGE: begin
          if (not_off && pm <= 64'(crit_pm))
            bat_color = fast_on ? pblp_pkg::COLOR_AMBER : pblp_pkg::COLOR_OFF;
          else if (not_off && pm <= 64'(low_pm))
            bat_color = slow_on ? pblp_pkg::COLOR_AMBER : pblp_pkg::COLOR_OFF;
          else
            bat_color = pblp_pkg::COLOR_OFF;
        end
        pblp_pkg::CHG_ERROR:
          bat_color = fast_on ? pblp_pkg::COLOR_AMBER : pblp_pkg::COLOR_OFF;
        pblp_pkg::CHG_IDLE: begin
          if (idle && bat_cnt >= 4'd8) bat_color = pblp_pkg::COLOR_AMBER;
          else bat_color = pblp_pkg::COLOR_BLUE;
        end
        default: ;   // other charge states hold the color
      endcase
    end
    pins = {~bat_color[1], ~bat_color[0], ~pwr_color[1], ~pwr_color[0]};
  endtask

  task automatic check_pins(input logic [3:0] got);
    logic [3:0] want;
    if (pins_due_q.size() == 0) begin
      report_miss($sformatf("result %b with no request outstanding", got));
      return;
    end
    want = pins_due_q.pop_front();
    n_checked++;
    for (int i = 0; i < 4; i++)
      if (got[i] !== want[i])
        report_miss($sformatf("result %0d %s got %b want %b",
                              n_checked, pin_name[i], got[i], want[i]));
  endtask

  always @(posedge clk) begin
    logic [3:0] pins;
    if (!rst_n) begin
      crit_pm   = pblp_pkg::CRITICAL_PERMILLE_RST;
      low_pm    = pblp_pkg::LOW_PERMILLE_RST;
      full_pm   = pblp_pkg::FULL_PERMILLE_RST;
      pwr_auto  = 1'b1;
      bat_auto  = 1'b1;
      pwr_cnt   = 4'd0;
      bat_cnt   = 4'd0;
      was_susp  = 1'b0;
      pwr_color = pblp_pkg::COLOR_OFF;
      bat_color = pblp_pkg::COLOR_OFF;
      pins_due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      // retire before pushing so a same-edge request never matches itself
      if (out_tvalid && out_tready) check_pins(out_tdata[3:0]);
      if (in_tvalid && in_tready) begin
        led_predict(in_tdata[1:0], in_tdata[4:2], in_tdata[5],
                    in_tdata[6 +: CAP], in_tdata[6+CAP +: CAP], pins);
        pins_due_q.push_back(pins);
      end
    end
    n_pending <= pins_due_q.size();
  end

endmodule

FILE: tb/tb_power_battery_led_pattern.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_battery_led_pattern
// Drives tick requests and register writes into the LED pattern block.
// ----------------------------------------------------------------------------
// A directed burst hits thresholds, suspend entry, zero full capacity and
// every chipset/charge state; then random phases run under several register
// settings, including extremes and auto-disable. The checker predicts and
// compares; this module makes stimulus, watches for hangs and gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_power_battery_led_pattern;

  localparam int CAP        = pblp_pkg::CAPACITY_BITS_DEF;
  localparam int IN_W       = ((6 + 2*CAP + 7) / 8) * 8;
  localparam int HOLD_LEN   = 400;    // long output back-pressure, cycles
  localparam int DOG_LIMIT  = 4000;   // cycles with no handshake anywhere
  localparam int TAIL_LEN   = 40;     // longer than one request period

  // codes the package leaves unnamed
  localparam logic [1:0] CHIP_TRANS   = 2'd3;
  localparam logic [2:0] CHG_OTHER    = 3'd5;
  localparam logic [2:0] CHG_OTHER_HI = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                                in_tvalid  = 1'b0;
  logic                                in_tready;
  logic [IN_W-1:0]                     in_tdata   = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [7:0]                          out_tdata;
  logic                                cfg_valid  = 1'b0;
  logic                                cfg_ready;
  logic [pblp_pkg::CFG_INDEX_BITS-1:0] cfg_index  = '0;
  logic [pblp_pkg::PERMILLE_BITS-1:0]  cfg_data   = '0;

  int n_pending, n_errors, n_checked;

  // stimulus controls
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;
  int n_sent     = 0;
  int n_settings = 0;

  // current thresholds, used to aim random charge near them
  int unsigned cur_crit = 71, cur_low = 137, cur_full = 937;
  logic [1:0]  last_chip = pblp_pkg::CHIP_ON;

  always #5 clk = ~clk;

  power_battery_led_pattern #(.CAPACITY_BITS(CAP)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pblp_checker #(.CAP(CAP), .IN_W(IN_W)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .n_pending  (n_pending),
    .n_errors   (n_errors),
    .n_checked  (n_checked)
  );

  // ---------------------------------------------------------------------------
  // Result side: random ready bursts, or one long hold when asked.
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any handshake on any channel restarts the count.
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < DOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready) || !rst_n)
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no handshake for %0d cycles, %0d results pending",
             DOG_LIMIT, n_pending);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [IN_W-1:0] pack_tick(
      input logic [1:0] chip, input logic [2:0] chg, input logic idle,
      input logic [CAP-1:0] rem, input logic [CAP-1:0] full);
    logic [IN_W-1:0] d;
    d = '0;
    d[1:0]            = chip;
    d[4:2]            = chg;
    d[5]              = idle;
    d[6 +: CAP]       = rem;
    d[6+CAP +: CAP]   = full;
    return d;
  endfunction

  // offer one request; valid stays up unless an idle burst follows
  task automatic send_tick(input logic [IN_W-1:0] d);
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    n_sent++;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  task automatic cfg_write(input pblp_pkg::reg_index_t idx,
                           input logic [pblp_pkg::PERMILLE_BITS-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input int unsigned crit, input int unsigned low,
                            input int unsigned full, input logic pa, input logic ba);
    drain();
    cfg_write(pblp_pkg::REG_CRITICAL_PERMILLE, crit[pblp_pkg::PERMILLE_BITS-1:0]);
    cfg_write(pblp_pkg::REG_LOW_PERMILLE, low[pblp_pkg::PERMILLE_BITS-1:0]);
    cfg_write(pblp_pkg::REG_FULL_PERMILLE, full[pblp_pkg::PERMILLE_BITS-1:0]);
    cfg_write(pblp_pkg::REG_POWER_AUTO_ENABLE,
              {{(pblp_pkg::PERMILLE_BITS-1){1'b0}}, pa});
    cfg_write(pblp_pkg::REG_BATTERY_AUTO_ENABLE,
              {{(pblp_pkg::PERMILLE_BITS-1){1'b0}}, ba});
    cfg_valid <= 1'b0;
    cur_crit = crit;
    cur_low  = low;
    cur_full = full;
    n_settings++;
  endtask

  // random tick: chipset state tends to persist so suspend runs go past 16
  // ticks, charge is often aimed at a threshold
  task automatic rand_tick();
    logic [1:0]  chip;
    logic [2:0]  chg;
    logic        idle;
    int unsigned full, target;
    int          rem;
    if ($urandom_range(0, 99) < 15) last_chip = 2'($urandom_range(0, 3));
    chip = last_chip;
    if ($urandom_range(0, 99) < 88) chg = 3'($urandom_range(0, 4));
    else chg = 3'($urandom_range(5, 7));
    idle = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: begin
        full = 0;
        rem  = $urandom_range(0, 65535);
      end
      1, 2, 3: begin
        full = $urandom_range(0, 65535);
        rem  = $urandom_range(0, 65535);
      end
      default: begin
        full = $urandom_range(1, 65535);
        case ($urandom_range(0, 3))
          0: target = cur_crit;
          1: target = cur_low;
          2: target = cur_full;
          default: target = $urandom_range(0, 1000);
        endcase
        rem = int'((full * target) / 1000) + $urandom_range(0, 4) - 2;
        if (rem < 0) rem = 0;
        if (rem > 65535) rem = 65535;
      end
    endcase
    send_tick(pack_tick(chip, chg, idle, rem[CAP-1:0], full[CAP-1:0]));
  endtask

  task automatic run_phase(input int n);
    repeat (n) rand_tick();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks at reset thresholds (71 / 137 / 937)
    send_tick(pack_tick(pblp_pkg::CHIP_OFF, pblp_pkg::CHG_CHARGE, 1'b0,
                        16'd0, 16'd0));                                   // unknown full
    send_tick(pack_tick(pblp_pkg::CHIP_ON, pblp_pkg::CHG_NEAR_FULL, 1'b1,
                        16'hFFFF, 16'hFFFF));
    repeat (6)                                                            // suspend entry
      send_tick(pack_tick(pblp_pkg::CHIP_SUSPEND, pblp_pkg::CHG_DISCHARGE, 1'b0,
                          16'd71, 16'd1000));
    send_tick(pack_tick(CHIP_TRANS, pblp_pkg::CHG_DISCHARGE, 1'b0, 16'd137, 16'd1000));
    send_tick(pack_tick(pblp_pkg::CHIP_SUSPEND, pblp_pkg::CHG_DISCHARGE, 1'b0,
                        16'd72, 16'd1000));
    send_tick(pack_tick(pblp_pkg::CHIP_ON, pblp_pkg::CHG_DISCHARGE, 1'b0,
                        16'd138, 16'd1000));
    send_tick(pack_tick(pblp_pkg::CHIP_OFF, pblp_pkg::CHG_DISCHARGE, 1'b0,
                        16'd10, 16'd1000));
    send_tick(pack_tick(pblp_pkg::CHIP_ON, pblp_pkg::CHG_CHARGE, 1'b0, 16'd937, 16'd1000));
    send_tick(pack_tick(pblp_pkg::CHIP_ON, pblp_pkg::CHG_CHARGE, 1'b0, 16'd936, 16'd1000));
    send_tick(pack_tick(pblp_pkg::CHIP_ON, pblp_pkg::CHG_ERROR, 1'b0, 16'd500, 16'd1000));
    send_tick(pack_tick(pblp_pkg::CHIP_ON, pblp_pkg::CHG_IDLE, 1'b1, 16'd500, 16'd1000));
    send_tick(pack_tick(pblp_pkg::CHIP_ON, pblp_pkg::CHG_IDLE, 1'b0, 16'd500, 16'd1000));
    send_tick(pack_tick(pblp_pkg::CHIP_ON, CHG_OTHER, 1'b1, 16'd500, 16'd1000));
    send_tick(pack_tick(CHIP_TRANS, CHG_OTHER_HI, 1'b0, 16'd1, 16'd2));
    send_tick(pack_tick(pblp_pkg::CHIP_ON, pblp_pkg::CHG_CHARGE, 1'b0,
                        16'hFFFF, 16'd1));                                // permille > 1000
    send_tick(pack_tick(pblp_pkg::CHIP_ON, pblp_pkg::CHG_DISCHARGE, 1'b0, 16'd0, 16'd0));
    send_tick(pack_tick(pblp_pkg::CHIP_SUSPEND, pblp_pkg::CHG_IDLE, 1'b1,
                        16'hAAAA, 16'h5555));

    // random phases over register settings
    set_config(71, 137, 937, 1'b1, 1'b1);
    run_phase(100);
    set_config(0, 0, 0, 1'b1, 1'b1);
    run_phase(100);
    set_config(1023, 1023, 1023, 1'b1, 1'b1);
    run_phase(100);
    set_config(1000, 1000, 0, 1'b1, 1'b1);
    run_phase(100);
    set_config($urandom_range(0, 300), $urandom_range(0, 600), $urandom_range(500, 1023),
               1'b0, 1'b1);
    run_phase(100);
    set_config($urandom_range(0, 300), $urandom_range(0, 600), $urandom_range(500, 1023),
               1'b1, 1'b0);
    run_phase(100);
    set_config(200, 400, 800, 1'b0, 1'b0);
    run_phase(30);

    // long result hold while requests keep coming back to back
    set_config($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
               1'b1, 1'b1);
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    run_phase(24);
    tx_idle_en = 1'b1;
    run_phase(50);
    drain();                       // sender waits for every result
    run_phase(50);

    // last stretch runs at full rate on both sides
    set_config(71, 137, 937, 1'b1, 1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_phase(100);

    drain();
    repeat (TAIL_LEN) @(posedge clk);

    $display("Ran %0d ticks (%0d results checked) over %0d register settings,",
             n_sent, n_checked, n_settings);
    $display("with random idling, a %0d-cycle result hold and a full-rate finish.",
             HOLD_LEN);
    if (n_errors == 0 && n_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, n_pending);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/pblp_pkg.sv
design/pblp_ctrl.sv
design/pblp_datapath.sv
design/power_battery_led_pattern.sv
tb/pblp_checker.sv
tb/tb_power_battery_led_pattern.sv
